// File: hw/rtl/pqem_pkg.sv
// shared types, codes and constants of the extract-max priority queue
`default_nettype none

package pqem_pkg;

    // default queue depth
    localparam int PQ_DEPTH = 32;

    // field widths
    localparam int OP_W        = 2;
    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;
    localparam int COUNT_OUT_W = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // value returned when nothing is extracted
    localparam logic [VALUE_W-1:0] NO_VALUE = '1;

    // one stored queue entry
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [VALUE_W-1:0]       value;
    } entry_t;

    // control shared by every cell of the row
    typedef struct packed {
        logic load;
        logic rotate;
        logic compact;
    } cell_ctrl_t;

    // one result item
    typedef struct packed {
        logic                   is_empty;
        logic                   is_full;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   add_dropped;
        logic                   was_empty;
        logic [VALUE_W-1:0]     out_value;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pqem_cell.sv
// one storage cell of the queue row: holds an entry, loads, rotates or closes a gap
`default_nettype none

module pqem_cell
    import pqem_pkg::*;
(
    input  wire logic       aclk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       hit,
    input  wire entry_t     new_entry,
    input  wire entry_t     up_entry,
    output      entry_t     entry
);

    entry_t ent_reg;
    entry_t ent_next;

    // load a new entry here, or take the neighbour's entry
    always_comb begin
        ent_next = ent_reg;
        if (ctrl.load && hit) begin
            ent_next = new_entry;
        end else if (ctrl.rotate || (ctrl.compact && hit)) begin
            ent_next = up_entry;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign entry = ent_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pqem_scan.sv
// maximum tracker at the head of the row: watches entries as they rotate past
`default_nettype none

module pqem_scan
    import pqem_pkg::*;
#(
    parameter int DEPTH = PQ_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         run,
    input  wire entry_t                       head,
    input  wire logic [$clog2(DEPTH+1)-1:0]   count,
    output      logic                         last,
    output      logic [$clog2(DEPTH)-1:0]     best_idx,
    output      logic [VALUE_W-1:0]           best_value
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [IDX_W-1:0]         step_reg;
    logic [IDX_W-1:0]         step_next;
    logic signed [PRIO_W-1:0] best_prio_reg;
    logic [VALUE_W-1:0]       best_value_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic                     take;

    // step counter: the entry at the head is the one of this arrival place
    always_comb begin
        step_next = run ? step_reg + IDX_W'(1) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    // first held entry starts the search, a strictly larger priority replaces it
    assign take = run && ((step_reg == '0) ||
                          ((CNT_W'(step_reg) < count) && (head.prio > best_prio_reg)));

    always_ff @(posedge aclk) begin
        if (take) begin
            best_prio_reg  <= head.prio;
            best_value_reg <= head.value;
            best_idx_reg   <= step_reg;
        end
    end

    assign last       = run && (step_reg == IDX_W'(DEPTH-1));
    assign best_idx   = best_idx_reg;
    assign best_value = best_value_reg;

endmodule

`default_nettype wire

// File: hw/rtl/priority_queue_extract_max.sv
// top level of the extract-max priority queue: control, cell row and output stage
// ---------------------------------------------------------------------------
// Fixed-depth priority queue held in a row of DEPTH cells in arrival order.
// Input channel s_: s_tuser carries the operation (add, extract, clear),
// s_tdata the value and priority of an add. Result channel m_: one result
// item per input item, carrying the extracted value and the queue status.
// Add, clear and unused codes complete in the idle state: a new item may be
// accepted in every cycle while the result side keeps draining, and its
// result goes through the pending register, then the output register, to
// m_tvalid. An extract rotates the whole row once past the maximum tracker
// at cell 0 (state SCAN), then closes the gap (state DEL) before the next
// item is accepted; its result takes the same registered path to m_tvalid.
// Ties go to the earliest arrival. Extract on an empty queue answers at once.
// A pending register and the output register part the two sides, so one
// item is still taken while a result waits; beyond that s_tready drops until
// m_tready frees the output. Reset empties the queue and drops any result
// that has not been taken; stored entries are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_queue_extract_max_core
    import pqem_pkg::*;
#(
    parameter int DEPTH = PQ_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [47:0] s_tdata,  // entry_value[31:0], entry_priority[47:32]
    input  wire logic [1:0]  s_tuser,  // operation[1:0]
    // result item
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [47:0] m_tdata   // out_value[31:0], was_empty[32], add_dropped[33],
                                       // entry_count[39:34], is_full[40], is_empty[41]
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DEL  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    result_t          pend_reg;
    result_t          pend_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    result_t          out_reg;
    result_t          out_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic               out_free;
    logic               pend_move;
    logic               in_acc;
    logic               full;
    logic               res_load;
    logic [VALUE_W-1:0] res_value;
    logic               res_empty;
    logic               res_drop;
    cell_ctrl_t         ctrl;
    entry_t             new_entry;
    entry_t             cell_q [DEPTH];
    logic               scan_run;
    logic               scan_last;
    logic [IDX_W-1:0]   best_idx;
    logic [VALUE_W-1:0] best_value;

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_free;
    assign s_tready  = (state_reg == ST_IDLE) && (!pend_valid_reg || out_free);
    assign in_acc    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(DEPTH));

    assign new_entry.value = s_tdata[31:0];
    assign new_entry.prio  = s_tdata[47:32];

    // sequencer and result build
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg && !pend_move;
        ctrl            = '0;
        res_load        = 1'b0;
        res_value       = NO_VALUE;
        res_empty       = 1'b0;
        res_drop        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_tuser)
                        OP_ADD: begin
                            res_load = 1'b1;
                            if (full) begin
                                res_drop = 1'b1;
                            end else begin
                                ctrl.load  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                res_load  = 1'b1;
                                res_empty = 1'b1;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            res_load   = 1'b1;
                            count_next = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                ctrl.rotate = 1'b1;
                if (scan_last) begin
                    state_next = ST_DEL;
                end
            end
            ST_DEL: begin
                ctrl.compact = 1'b1;
                count_next   = count_reg - CNT_W'(1);
                res_load     = 1'b1;
                res_value    = best_value;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (res_load) begin
            pend_next.out_value   = res_value;
            pend_next.was_empty   = res_empty;
            pend_next.add_dropped = res_drop;
            pend_next.entry_count = COUNT_OUT_W'(count_next);
            pend_next.is_full     = (count_next == CNT_W'(DEPTH));
            pend_next.is_empty    = (count_next == '0);
            pend_valid_next       = 1'b1;
        end
    end

    // output stage
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (pend_move) begin
            out_next       = pend_reg;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg};

    // row of cells, ring-connected; each decodes its own place
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic hit;
        assign hit = ctrl.load ? (count_reg == CNT_W'(i)) : (IDX_W'(i) >= best_idx);
        pqem_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .hit       (hit),
            .new_entry (new_entry),
            .up_entry  (cell_q[(i + 1) % DEPTH]),
            .entry     (cell_q[i])
        );
    end

    // maximum search at the head of the row
    assign scan_run = (state_reg == ST_SCAN);

    pqem_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .run        (scan_run),
        .head       (cell_q[0]),
        .count      (count_reg),
        .last       (scan_last),
        .best_idx   (best_idx),
        .best_value (best_value)
    );

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_del_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEL) |-> (count_reg != '0))
        else $error("gap closed on an empty queue");

    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (s_tuser == OP_CLEAR)) |=> (pend_valid_reg && pend_reg.is_empty))
        else $error("clear did not report an empty queue");

    a_pend_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("pending result not moved to a free output");

endmodule

`default_nettype wire

// File: sim/tb_priority_queue_extract_max_core.sv
// self-checking testbench for the extract-max priority queue core
module tb_priority_queue_extract_max_core;
    import pqem_pkg::*;

    localparam int RUN_LIMIT    = 500000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int SETTLE_CYCLES = 8;
    localparam int MODE_LENGTH  = 70;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // queue copy and the results it predicts
    class queue_scoreboard;
        logic [VALUE_W-1:0]       held_value[PQ_DEPTH];
        logic signed [PRIO_W-1:0] held_prio[PQ_DEPTH];
        int                       held_count;
        result_t                  expected_results[$];
        int                       mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        // apply one accepted item to the queue copy and queue its result
        function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                logic signed [PRIO_W-1:0] prio);
            result_t r;
            int      best;
            int      i;
            r = '0;
            r.out_value = NO_VALUE;
            case (op)
                OP_ADD: begin
                    if (held_count >= PQ_DEPTH) begin
                        r.add_dropped = 1'b1;
                    end else begin
                        held_value[held_count] = value;
                        held_prio[held_count]  = prio;
                        held_count++;
                    end
                end
                OP_EXTRACT: begin
                    if (held_count == 0) begin
                        r.was_empty = 1'b1;
                    end else begin
                        // strict compare keeps the earliest arrival on a tie
                        best = 0;
                        for (i = 1; i < held_count; i++) begin
                            if (held_prio[i] > held_prio[best]) best = i;
                        end
                        r.out_value = held_value[best];
                        // close the gap, keeping arrival order
                        for (i = best; i + 1 < held_count; i++) begin
                            held_value[i] = held_value[i + 1];
                            held_prio[i]  = held_prio[i + 1];
                        end
                        held_count--;
                    end
                end
                OP_CLEAR: begin
                    held_count = 0;
                end
                default: begin
                end
            endcase
            r.entry_count = held_count[COUNT_OUT_W-1:0];
            r.is_full     = (held_count == PQ_DEPTH);
            r.is_empty    = (held_count == 0);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // compare a result item with the oldest prediction
        function void check_item(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("out_value", want.out_value, got.out_value);
            compare_field("was_empty", VALUE_W'(want.was_empty), VALUE_W'(got.was_empty));
            compare_field("add_dropped", VALUE_W'(want.add_dropped),
                          VALUE_W'(got.add_dropped));
            compare_field("entry_count", VALUE_W'(want.entry_count),
                          VALUE_W'(got.entry_count));
            compare_field("is_full", VALUE_W'(want.is_full), VALUE_W'(got.is_full));
            compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // entry_value[31:0], entry_priority[47:32]
    logic [1:0]  s_tuser  = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // out_value[31:0], was_empty[32], add_dropped[33],
                                  // entry_count[39:34], is_full[40], is_empty[41]

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;

    queue_scoreboard queue_sb = new();

    priority_queue_extract_max_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[priority_queue_extract_max_core] ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= receiver_stall_pct);
    end

    // watch both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                queue_sb.note_item(s_tuser, s_tdata[31:0], s_tdata[47:32]);
            end
            if (m_tvalid && m_tready) begin
                queue_sb.check_item(result_t'(m_tdata[41:0]));
            end
        end
    end

    // present one item, with random idle cycles ahead of it, until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                             input logic [PRIO_W-1:0] prio);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {prio, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // extremes, ties, empty and unused-code cases
    task automatic send_directed();
        send_item(OP_CLEAR, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_UNUSED, 32'hffff_ffff, 16'hffff);
        send_item(OP_ADD, 32'h7fff_ffff, 16'h8000);
        send_item(OP_ADD, 32'h8000_0000, 16'h7fff);
        send_item(OP_ADD, 32'h0000_0000, 16'h7fff);
        send_item(OP_ADD, 32'hffff_ffff, 16'h0000);
        send_item(OP_ADD, 32'h0000_0001, 16'h8000);
        send_item(OP_UNUSED, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_ADD, 32'h0000_0002, 16'hffff);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
        send_item(OP_ADD, 32'h0000_0005, 16'h0000);
        send_item(OP_CLEAR, 32'h0, 16'h0);
        send_item(OP_EXTRACT, 32'h0, 16'h0);
    endtask

    // alternate add-heavy and extract-heavy stretches so the queue fills and drains
    task automatic send_random(input int n_items);
        int                k;
        int                pick;
        bit                filling;
        logic [OP_W-1:0]   op;
        logic [PRIO_W-1:0] prio;
        filling = 1'b1;
        for (k = 0; k < n_items; k++) begin
            if (k % MODE_LENGTH == 0 && k != 0) filling = !filling;
            pick = $urandom_range(99);
            if (pick < (filling ? 82 : 15)) begin
                op = OP_ADD;
            end else if (pick < 95) begin
                op = OP_EXTRACT;
            end else if (pick < 98) begin
                op = OP_CLEAR;
            end else begin
                op = OP_UNUSED;
            end
            // narrow priorities make ties common
            case ($urandom_range(3))
                0: prio = 16'($signed($urandom_range(6)) - 3);
                1: begin
                    case ($urandom_range(3))
                        0: prio = 16'h8000;
                        1: prio = 16'h7fff;
                        2: prio = 16'hffff;
                        default: prio = 16'h0000;
                    endcase
                end
                default: prio = 16'($urandom);
            endcase
            send_item(op, $urandom, prio);
        end
    endtask

    // main sequence
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // no idling
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_directed();
        send_random(RANDOM_ITEMS / 4);
        // sender idle
        sender_idle_pct    = 68;
        receiver_stall_pct = 0;
        send_random(RANDOM_ITEMS / 4);
        // receiver stalling
        sender_idle_pct    = 0;
        receiver_stall_pct = 68;
        send_random(RANDOM_ITEMS / 4);
        // both sides
        sender_idle_pct    = 26;
        receiver_stall_pct = 26;
        send_random(RANDOM_ITEMS / 4);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (queue_sb.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (queue_sb.mismatches == 0 && queue_sb.expected_results.size() == 0) begin
            $display("[priority_queue_extract_max_core] OK");
        end else begin
            $display("[priority_queue_extract_max_core] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pqem_pkg.sv
hw/rtl/pqem_cell.sv
hw/rtl/pqem_scan.sv
hw/rtl/priority_queue_extract_max.sv
sim/tb_priority_queue_extract_max_core.sv
